// ===== hw/rtl/pgm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_pkg
// shared types, constants and table functions of the gray pam soft demapper
// ----------------------------------------------------------------------------
package pgm_pkg;

    localparam int MAX_BPS   = 4;
    localparam int NUM_LANES = 4;
    localparam int ACC_W     = 26;
    localparam int MET_W     = 24;

    localparam logic       CFG_BPS = 1'b0;
    localparam logic       CFG_INV = 1'b1;
    localparam logic       ACT_MOD = 1'b0;
    localparam logic       ACT_DEM = 1'b1;
    localparam logic       KIND_SYM = 1'b0;
    localparam logic       KIND_LLR = 1'b1;

    // far below any metric, so the first max-star with it returns the metric
    localparam logic signed [ACC_W-1:0] ACC_FLOOR = {1'b1, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic               action;
        logic [3:0]         data_bits;
        logic [2:0]         bit_count;
        logic signed [15:0] sample;
    } t_in_item;

    typedef struct packed {
        logic               result_kind;
        logic signed [15:0] symbol;
        logic signed [23:0] llr;
        logic [1:0]         bit_index;
        logic               last;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SYM,
        ST_DIFF,
        ST_SQR,
        ST_MUL,
        ST_ACC,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic ready;
        logic latch;
        logic load_d;
        logic load_sq;
        logic load_m;
        logic acc;
        logic emit_sym;
        logic emit_llr;
    } t_cmd;

    typedef struct packed {
        logic new_demod;
        logic point_last;
        logic bit_last;
        logic out_free;
    } t_status;

    // normalized q3.12 gray constellation point
    function automatic logic signed [15:0] point_q12(input logic [2:0] bps,
                                                     input logic [3:0] j);
        logic signed [15:0] p;
        logic [14:0]        mag;
        mag = 15'd0;
        unique case (bps)
            3'd1: mag = 15'd4096;
            3'd2: begin
                unique case (j[0])
                    1'b0: mag = 15'd1832;
                    default: mag = 15'd5495;
                endcase
            end
            3'd3: begin
                unique case (j[1:0])
                    2'd0: mag = 15'd2681;
                    2'd1: mag = 15'd894;
                    2'd2: mag = 15'd4469;
                    default: mag = 15'd6257;
                endcase
            end
            default: begin
                unique case (j[2:0])
                    3'd0: mag = 15'd2221;
                    3'd1: mag = 15'd3110;
                    3'd2: mag = 15'd1333;
                    3'd3: mag = 15'd444;
                    3'd4: mag = 15'd4887;
                    3'd5: mag = 15'd3998;
                    3'd6: mag = 15'd5776;
                    default: mag = 15'd6664;
                endcase
            end
        endcase
        // top index bit picks the sign
        if (((bps == 3'd1) && j[0]) || ((bps == 3'd2) && j[1]) ||
            ((bps == 3'd3) && j[2]) || ((bps == 3'd4) && j[3])) begin
            p = -$signed({1'b0, mag});
        end else begin
            p = $signed({1'b0, mag});
        end
        return p;
    endfunction

    // ln(1 + exp(-x)) in q.8 for x = idx / 4
    function automatic logic [7:0] corr_lut(input logic [4:0] idx);
        logic [7:0] c;
        unique case (idx)
            5'd0:  c = 8'd177;
            5'd1:  c = 8'd147;
            5'd2:  c = 8'd121;
            5'd3:  c = 8'd99;
            5'd4:  c = 8'd80;
            5'd5:  c = 8'd64;
            5'd6:  c = 8'd52;
            5'd7:  c = 8'd41;
            5'd8:  c = 8'd32;
            5'd9:  c = 8'd26;
            5'd10: c = 8'd20;
            5'd11: c = 8'd16;
            5'd12: c = 8'd12;
            5'd13: c = 8'd10;
            5'd14: c = 8'd8;
            5'd15: c = 8'd6;
            5'd16: c = 8'd5;
            5'd17: c = 8'd4;
            5'd18: c = 8'd3;
            5'd19: c = 8'd2;
            5'd20: c = 8'd2;
            5'd21: c = 8'd1;
            5'd22: c = 8'd1;
            5'd23: c = 8'd1;
            5'd24: c = 8'd1;
            default: c = 8'd0;
        endcase
        return c;
    endfunction

    // jacobian logarithm with table correction
    function automatic logic signed [ACC_W-1:0] jacobian_max(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b
    );
        logic signed [ACC_W:0]   d;
        logic [ACC_W:0]          ad;
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] res;
        d  = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        ad = d[ACC_W] ? $unsigned(-d) : $unsigned(d);
        hi = d[ACC_W] ? b : a;
        if (ad >= (ACC_W+1)'(2048)) begin
            res = hi;
        end else begin
            res = hi + $signed({{(ACC_W-8){1'b0}}, corr_lut(ad[10:6])});
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/pgm_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_ctrl
// sequencer for modulate and demodulate transactions
// ----------------------------------------------------------------------------
module pgm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pgm_pkg::t_status i_status,
    output pgm_pkg::t_cmd    o_cmd
);

    pgm_pkg::t_state r_state;
    pgm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pgm_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            pgm_pkg::ST_IDLE: begin
                o_cmd.ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state = i_status.new_demod ? pgm_pkg::ST_DIFF : pgm_pkg::ST_SYM;
                end
            end
            pgm_pkg::ST_SYM: begin
                if (i_status.out_free) begin
                    o_cmd.emit_sym = 1'b1;
                    n_state = pgm_pkg::ST_IDLE;
                end
            end
            pgm_pkg::ST_DIFF: begin
                o_cmd.load_d = 1'b1;
                n_state = pgm_pkg::ST_SQR;
            end
            pgm_pkg::ST_SQR: begin
                o_cmd.load_sq = 1'b1;
                n_state = pgm_pkg::ST_MUL;
            end
            pgm_pkg::ST_MUL: begin
                o_cmd.load_m = 1'b1;
                n_state = pgm_pkg::ST_ACC;
            end
            pgm_pkg::ST_ACC: begin
                o_cmd.acc = 1'b1;
                n_state = i_status.point_last ? pgm_pkg::ST_EMIT : pgm_pkg::ST_DIFF;
            end
            pgm_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit_llr = 1'b1;
                    if (i_status.bit_last) begin
                        n_state = pgm_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = pgm_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/pgm_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pgm_dp
// config registers, shared metric unit, max-star lanes and output register
// ----------------------------------------------------------------------------
module pgm_dp (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [15:0]       i_cfg_data,
    input  pgm_pkg::t_in_item i_in_data,
    input  pgm_pkg::t_cmd     i_cmd,
    output pgm_pkg::t_status  o_status,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output pgm_pkg::t_out_item o_out_data
);

    logic [2:0]  r_cfg_bps;
    logic [15:0] r_inv;

    logic        r_action;
    logic [2:0]  r_bps;
    logic [2:0]  r_cnt;
    logic [3:0]  r_idx;
    logic signed [15:0] r_y;
    logic [3:0]  r_j;
    logic [1:0]  r_b;
    logic [15:0] r_ad;
    logic [31:0] r_sq;
    logic [pgm_pkg::MET_W-1:0] r_m;
    logic signed [pgm_pkg::ACC_W-1:0] r_l0 [pgm_pkg::NUM_LANES];
    logic signed [pgm_pkg::ACC_W-1:0] r_l1 [pgm_pkg::NUM_LANES];
    logic        r_out_valid;
    pgm_pkg::t_out_item r_out;

    logic [2:0]  w_bps_eff;
    logic [2:0]  w_cnt_eff;
    logic [3:0]  w_mask;
    logic [3:0]  w_last_j;
    logic signed [15:0] w_point;
    logic signed [16:0] w_d;
    logic [47:0] w_prod;
    logic [47:0] w_round;
    logic signed [pgm_pkg::ACC_W-1:0] w_nm;
    logic signed [pgm_pkg::ACC_W:0]   w_llr;
    logic signed [23:0] w_llr_sat;
    logic        w_out_free;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_bps <= 3'd1;
            r_inv     <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pgm_pkg::CFG_BPS: r_cfg_bps <= i_cfg_data[2:0];
                default:          r_inv     <= i_cfg_data;
            endcase
        end
    end

    always_comb begin
        if (r_cfg_bps == 3'd0) begin
            w_bps_eff = 3'd1;
        end else if (r_cfg_bps > 3'(pgm_pkg::MAX_BPS)) begin
            w_bps_eff = 3'(pgm_pkg::MAX_BPS);
        end else begin
            w_bps_eff = r_cfg_bps;
        end
        if (i_in_data.bit_count == 3'd0) begin
            w_cnt_eff = 3'd1;
        end else if (i_in_data.bit_count > w_bps_eff) begin
            w_cnt_eff = w_bps_eff;
        end else begin
            w_cnt_eff = i_in_data.bit_count;
        end
        for (int k = 0; k < 4; k++) begin
            w_mask[k]   = (3'(k) < w_cnt_eff);
            w_last_j[k] = (3'(k) < r_bps);
        end
    end

    // metric path: |y - c|, square, scale by inverse variance
    assign w_point = pgm_pkg::point_q12(r_bps, r_j);
    assign w_d     = {r_y[15], r_y} - {w_point[15], w_point};
    assign w_prod  = r_sq * r_inv;
    assign w_round = w_prod + 48'd8388608;
    assign w_nm    = -$signed({{(pgm_pkg::ACC_W-pgm_pkg::MET_W){1'b0}}, r_m});

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_action <= i_in_data.action;
            r_bps    <= w_bps_eff;
            r_cnt    <= w_cnt_eff;
            r_idx    <= i_in_data.data_bits & w_mask;
            r_y      <= i_in_data.sample;
        end
        if (i_cmd.load_d) begin
            r_ad <= w_d[16] ? 16'(-w_d) : w_d[15:0];
        end
        if (i_cmd.load_sq) begin
            r_sq <= r_ad * r_ad;
        end
        if (i_cmd.load_m) begin
            r_m <= w_round[47:24];
        end
    end

    // one lane per bit, each keeps the max-star for bit clear and bit set
    always_ff @(posedge i_clk) begin
        for (int b = 0; b < pgm_pkg::NUM_LANES; b++) begin
            if (i_cmd.latch) begin
                r_l0[b] <= pgm_pkg::ACC_FLOOR;
                r_l1[b] <= pgm_pkg::ACC_FLOOR;
            end else if (i_cmd.acc) begin
                if (r_j[b]) begin
                    r_l1[b] <= pgm_pkg::jacobian_max(r_l1[b], w_nm);
                end else begin
                    r_l0[b] <= pgm_pkg::jacobian_max(r_l0[b], w_nm);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j <= 4'd0;
            r_b <= 2'd0;
        end else begin
            if (i_cmd.latch) begin
                r_j <= 4'd0;
                r_b <= 2'd0;
            end else begin
                if (i_cmd.acc) begin
                    r_j <= r_j + 4'd1;
                end
                if (i_cmd.emit_llr) begin
                    r_b <= r_b + 2'd1;
                end
            end
        end
    end

    // llr with 24 bit saturation
    always_comb begin
        w_llr = {r_l0[r_b][pgm_pkg::ACC_W-1], r_l0[r_b]} -
                {r_l1[r_b][pgm_pkg::ACC_W-1], r_l1[r_b]};
        if (w_llr > (pgm_pkg::ACC_W+1)'(signed'(24'sh7fffff))) begin
            w_llr_sat = 24'sh7fffff;
        end else if (w_llr < (pgm_pkg::ACC_W+1)'(signed'(-24'sh800000))) begin
            w_llr_sat = -24'sh800000;
        end else begin
            w_llr_sat = w_llr[23:0];
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit_sym || i_cmd.emit_llr) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit_sym) begin
            r_out.result_kind <= pgm_pkg::KIND_SYM;
            r_out.symbol      <= pgm_pkg::point_q12(r_bps, r_idx);
            r_out.llr         <= '0;
            r_out.bit_index   <= 2'd0;
            r_out.last        <= 1'b1;
        end else if (i_cmd.emit_llr) begin
            r_out.result_kind <= pgm_pkg::KIND_LLR;
            r_out.symbol      <= '0;
            r_out.llr         <= w_llr_sat;
            r_out.bit_index   <= r_b;
            r_out.last        <= o_status.bit_last;
        end
    end

    always_comb begin
        o_status.new_demod  = (i_in_data.action == pgm_pkg::ACT_DEM);
        o_status.point_last = (r_j == w_last_j) && (r_action == pgm_pkg::ACT_DEM);
        o_status.bit_last   = (({1'b0, r_b} + 3'd1) == r_cnt);
        o_status.out_free   = w_out_free;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hw/rtl/pam_gray_modem_soft_demap_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pam_gray_modem_soft_demap_top
// gray-mapped pam modulator and max-star llr demapper, fixed point
// ----------------------------------------------------------------------------
// A modulate transaction (action 0) returns one q3.12 amplitude, and the input
// is free again once that amplitude is written to the output register. A
// demodulate transaction (action 1) returns bit_count llr results, with
// bit_count clamped to 1 up to the bits per symbol, bit 0 first, last set on
// the final one. The single metric unit (subtract, square, scale by inverse
// variance) serves one constellation point at a time through the diff, square,
// scale and accumulate states, while four max-star lanes update all bit
// accumulators from that one metric. Input is taken only while the sequencer
// is idle; the output register lets a new transaction in while the last result
// still waits downstream. Config writes are applied immediately and must only
// be made while the block is idle.
// ----------------------------------------------------------------------------
module pam_gray_modem_soft_demap_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // config write port
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    // input transaction channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  pgm_pkg::t_in_item  i_in_data,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output pgm_pkg::t_out_item o_out_data
);

    pgm_pkg::t_cmd    w_cmd;
    pgm_pkg::t_status w_status;

    // sequencer
    pgm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // metric unit, lanes, output register
    pgm_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // stall whenever the sequencer is busy
    assign o_in_stall = !w_cmd.ready;

    // a taken transaction keeps the input stalled in the next cycle
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after a transaction was taken");

    // symbol results are always the single, last result of a transaction
    a_sym_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == pgm_pkg::KIND_SYM))
        |-> (o_out_data.last && (o_out_data.llr == '0)))
        else $error("symbol result without last or with nonzero llr");

    // llr results carry a zero symbol field
    a_llr_sym_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.result_kind == pgm_pkg::KIND_LLR))
        |-> (o_out_data.symbol == '0))
        else $error("llr result with nonzero symbol");

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gray pam modulator and max-star llr demapper
// ----------------------------------------------------------------------------
// A directed table (register writes and transactions) runs first, then
// random phases under several register settings. Each accepted transaction
// is predicted by an in-bench model of the modem, or for a typed directed row
// by the symbol given in the row. Each result is compared field by field with
// the oldest pending expectation.
module tb;

    localparam int DEPTH     = 32;
    localparam int QF        = 28;
    localparam int TERMS     = 13;
    localparam int LIMIT     = 500000;
    localparam int HOLD_LEN  = 300;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic       i_cfg_index;
    logic [15:0] i_cfg_data;
    logic       i_in_valid;
    logic       o_in_stall;
    pgm_pkg::t_in_item   i_in_data;
    logic       o_out_valid;
    logic       i_out_stall;
    pgm_pkg::t_out_item  o_out_data;

    pam_gray_modem_soft_demap_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // model copy of the registers
    logic [2:0]  mdl_bps;
    logic [15:0] mdl_inv;
    longint unsigned corr_q8 [DEPTH];

    pgm_pkg::t_out_item pending_q [$];
    int  errors;
    int  cycles;
    bit  gaps_on;
    bit  hold_req;

    // directed table row: register write or transaction
    typedef struct {
        bit          is_cfg;
        logic        cfg_idx;
        logic [15:0] cfg_val;
        pgm_pkg::t_in_item item;
        bit          typed;
        logic [15:0] sym;
    } t_row;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= LIMIT) begin
                $display("[pam_gray_modem_soft_demap_top] ERROR");
                $finish;
            end
        end
    end

    // exp(-x) in q.28 for x in q.8, as (exp(-x/16))^16
    function automatic longint unsigned exp_neg(longint unsigned xq8);
        longint unsigned t, term, s;
        longint sum;
        t = xq8 << 16;
        term = 64'd1 << QF;
        sum = longint'(64'd1 << QF);
        for (int k = 1; k < TERMS; k++) begin
            term = ((term * t) >> QF) / k;
            if (k % 2) sum -= longint'(term);
            else sum += longint'(term);
        end
        s = (sum > 0) ? longint'(sum) : 0;
        for (int r = 0; r < 4; r++) s = (s * s) >> QF;
        return s;
    endfunction

    // ln(1+u) in q.28 via 2*atanh(u/(2+u))
    function automatic longint unsigned ln_one_plus(longint unsigned u);
        longint unsigned z, z2, p, acc;
        z = (u << QF) / ((64'd2 << QF) + u);
        z2 = (z * z) >> QF;
        p = z;
        acc = 0;
        for (int k = 0; k < TERMS; k++) begin
            acc += p / (2 * k + 1);
            p = (p * z2) >> QF;
        end
        return 2 * acc;
    endfunction

    function automatic int unsigned eff_bps();
        if (mdl_bps < 1) return 1;
        if (mdl_bps > pgm_pkg::MAX_BPS) return pgm_pkg::MAX_BPS;
        return mdl_bps;
    endfunction

    // gray point j, rounded |a|/sqrt(E) in q3.12 by integer search
    function automatic longint gray_point(int unsigned j, int unsigned bps);
        longint a;
        longint unsigned e, x, x4, lo, hi, mid, t, ax;
        a = 1 - 2 * longint'(j & 1);
        for (int unsigned k = 1; k < bps; k++)
            a = (1 - 2 * longint'((j >> k) & 1)) * ((longint'(1) << k) - a);
        e = ((64'd1 << (2 * bps)) - 1) / 3;
        ax = (a < 0) ? -a : a;
        x = ax * 4096;
        x4 = 4 * x * x;
        lo = 0;
        hi = 64'd1 << 17;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t = 2 * mid - 1;
            if (t * t * e <= x4) lo = mid;
            else hi = mid - 1;
        end
        if (lo > 32767) lo = 32767;
        return (a < 0) ? -longint'(lo) : longint'(lo);
    endfunction

    function automatic longint dist_metric(longint y, longint c);
        longint d;
        longint unsigned ad, sq, m;
        d = y - c;
        ad = (d < 0) ? -d : d;
        sq = ad * ad;
        m = (sq >> 24) * mdl_inv + (((sq & 64'hFFFFFF) * mdl_inv + (64'd1 << 23)) >> 24);
        return -longint'(m);
    endfunction

    function automatic longint jacobian(longint a, longint b);
        longint hi;
        longint unsigned diff, idx;
        hi = (a > b) ? a : b;
        diff = (a > b) ? a - b : b - a;
        if (diff >= 2048) return hi;
        idx = (diff * DEPTH) >> 11;
        return hi + longint'(corr_q8[idx]);
    endfunction

    // expected results of one transaction, appended to the pending queue
    function automatic void predict_results(pgm_pkg::t_in_item it);
        int unsigned bps, cnt, nsym;
        longint y, l0, l1, m, llr;
        bit v0, v1;
        pgm_pkg::t_out_item r;
        bps = eff_bps();
        cnt = it.bit_count;
        if (cnt < 1) cnt = 1;
        if (cnt > bps) cnt = bps;
        r = '0;
        if (it.action == pgm_pkg::ACT_MOD) begin
            r.result_kind = pgm_pkg::KIND_SYM;
            r.symbol = 16'(gray_point(it.data_bits & ((1 << cnt) - 1), bps));
            r.last = 1'b1;
            pending_q.push_back(r);
        end else begin
            y = it.sample;
            nsym = 1 << bps;
            for (int unsigned b = 0; b < cnt; b++) begin
                l0 = 0; l1 = 0; v0 = 0; v1 = 0;
                for (int unsigned j = 0; j < nsym; j++) begin
                    m = dist_metric(y, gray_point(j, bps));
                    if (((j >> b) & 1) == 0) begin
                        l0 = v0 ? jacobian(l0, m) : m;
                        v0 = 1;
                    end else begin
                        l1 = v1 ? jacobian(l1, m) : m;
                        v1 = 1;
                    end
                end
                llr = l0 - l1;
                if (llr > 8388607) llr = 8388607;
                if (llr < -8388608) llr = -8388608;
                r = '0;
                r.result_kind = pgm_pkg::KIND_LLR;
                r.llr = 24'(llr);
                r.bit_index = 2'(b);
                r.last = (b + 1 == cnt);
                pending_q.push_back(r);
            end
        end
    endfunction

    // wait for every pending result, then let the sequencer settle
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [15:0] val);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == pgm_pkg::CFG_BPS) mdl_bps = val[2:0];
        else mdl_inv = val;
    endtask

    // offer one transaction, hold it until accepted, then maybe idle
    task automatic send(pgm_pkg::t_in_item it, bit typed, logic [15:0] sym);
        pgm_pkg::t_out_item r;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (o_in_stall);
        if (typed) begin
            r = '0;
            r.result_kind = pgm_pkg::KIND_SYM;
            r.symbol = sym;
            r.last = 1'b1;
            pending_q.push_back(r);
        end else begin
            predict_results(it);
        end
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    function automatic t_row txn(logic act, logic [3:0] bits, logic [2:0] cnt,
                                 logic [15:0] smp, bit typed, logic [15:0] sym);
        t_row r;
        r.is_cfg = 0; r.cfg_idx = 0; r.cfg_val = 0;
        r.item.action = act;
        r.item.data_bits = bits;
        r.item.bit_count = cnt;
        r.item.sample = smp;
        r.typed = typed;
        r.sym = sym;
        return r;
    endfunction

    function automatic t_row reg_wr(logic idx, logic [15:0] val);
        t_row r;
        r = txn(pgm_pkg::ACT_MOD, 0, 0, 0, 0, 0);
        r.is_cfg = 1; r.cfg_idx = idx; r.cfg_val = val;
        return r;
    endfunction

    function automatic logic [15:0] rand_sample();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(gray_point($urandom_range(0, 15), eff_bps())
                          + $signed($urandom_range(0, 800)) - 400);
            default: return 16'($urandom);
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        pgm_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_q.size() == 0) begin
                $error("result with nothing pending: %p", o_out_data);
                errors++;
            end else begin
                e = pending_q.pop_front();
                if (o_out_data.result_kind !== e.result_kind) begin
                    $error("result_kind exp %0d got %0d", e.result_kind,
                           o_out_data.result_kind);
                    errors++;
                end
                if (o_out_data.symbol !== e.symbol) begin
                    $error("symbol exp %0d got %0d", e.symbol, o_out_data.symbol);
                    errors++;
                end
                if (o_out_data.llr !== e.llr) begin
                    $error("llr exp %0d got %0d", e.llr, o_out_data.llr);
                    errors++;
                end
                if (o_out_data.bit_index !== e.bit_index) begin
                    $error("bit_index exp %0d got %0d", e.bit_index,
                           o_out_data.bit_index);
                    errors++;
                end
                if (o_out_data.last !== e.last) begin
                    $error("last exp %0d got %0d", e.last, o_out_data.last);
                    errors++;
                end
            end
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 0;
                i_out_stall <= 1'b1;
                repeat (HOLD_LEN) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 4) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        t_row rows [$];
        pgm_pkg::t_in_item it;
        logic [2:0]  bps_set [9];
        logic [15:0] inv_set [9];

        errors = 0;
        gaps_on = 1;
        hold_req = 0;
        mdl_bps = 1;
        mdl_inv = 256;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        for (int i = 0; i < DEPTH; i++)
            corr_q8[i] = (ln_one_plus(exp_neg(i * 2048 / DEPTH)) + (64'd1 << (QF - 9)))
                         >> (QF - 8);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: reset values, extremes, clamps, short tail
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'h0, 3'd1, 0, 1, 16'd4096));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'hF, 3'd1, 0, 1, 16'hF000));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd1, 16'h0000, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd7, 16'h7FFF, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd0, 16'h8000, 0, 0));
        rows.push_back(reg_wr(pgm_pkg::CFG_BPS, 16'd4));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'h0, 3'd4, 0, 1, 16'd2221));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'hF, 3'd4, 0, 1, -16'sd6664));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'hF, 3'd2, 0, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'hA, 3'd0, 0, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'h5, 3'd7, 0, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd4, 16'h7FFF, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'hF, 3'd7, 16'h8000, 0, 0));
        rows.push_back(reg_wr(pgm_pkg::CFG_INV, 16'hFFFF));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd4, 16'h8000, 0, 0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd4, 16'h0100, 0, 0));
        rows.push_back(reg_wr(pgm_pkg::CFG_INV, 16'd1));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd4, 16'h7FFF, 0, 0));
        rows.push_back(reg_wr(pgm_pkg::CFG_BPS, 16'd0));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'hF, 3'd3, 0, 1, 16'hF000));
        rows.push_back(reg_wr(pgm_pkg::CFG_BPS, 16'd7));
        rows.push_back(txn(pgm_pkg::ACT_MOD, 4'h9, 3'd4, 0, 0, 0));
        rows.push_back(reg_wr(pgm_pkg::CFG_INV, 16'd0));
        rows.push_back(txn(pgm_pkg::ACT_DEM, 4'h0, 3'd4, 16'h1234, 0, 0));
        foreach (rows[i]) begin
            if (rows[i].is_cfg) write_reg(rows[i].cfg_idx, rows[i].cfg_val);
            else send(rows[i].item, rows[i].typed, rows[i].sym);
        end

        // random phases over several register settings
        bps_set = '{3'd1, 3'd2, 3'd3, 3'd4, 3'd4, 3'd0, 3'd5, 3'd3, 3'd4};
        inv_set = '{16'd256, 16'd1, 16'hFFFF, 16'd256, 16'd4096, 16'd0, 16'd512,
                    16'd64, 16'd256};
        for (int p = 0; p < 9; p++) begin
            if (p == 8) gaps_on = 0;    // last stretch without idling
            write_reg(pgm_pkg::CFG_BPS, {13'd0, bps_set[p] ^ 3'($urandom_range(0, 0))});
            write_reg(pgm_pkg::CFG_INV,
                      (p == 4) ? 16'($urandom_range(1, 65535)) : inv_set[p]);
            if (p == 3) hold_req = 1;   // block fills while the receiver holds
            for (int n = 0; n < 48; n++) begin
                it.action = 1'($urandom_range(0, 1));
                it.data_bits = 4'($urandom);
                it.bit_count = ($urandom_range(0, 4) == 0) ? 3'($urandom)
                                                            : 3'($urandom_range(1, 4));
                it.sample = rand_sample();
                send(it, 0, 0);
                if (n == 24 && p == 5) drain();   // sender waits for all results
            end
        end

        drain();
        repeat (80) @(posedge i_clk);
        if (errors == 0) begin
            $display("[pam_gray_modem_soft_demap_top] OK");
        end else begin
            $display("[pam_gray_modem_soft_demap_top] ERROR");
        end
        $finish;
    end

endmodule
